/* sv/y2r_pkg.sv */
// Shared types and constants for the YUYV 4:2:2 to RGB888 converter.
// No dependencies; every other file of the block uses this package.
package y2r_pkg;

  // Chroma bytes carry an offset of half scale.
  localparam int unsigned CHROMA_OFFSET = 128;
  // Largest channel value before output scaling.
  localparam logic [7:0]  PIX_MAX       = 8'd255;
  // Output scale is x * SCALE_NUM / 256.
  localparam logic [7:0]  SCALE_NUM     = 8'd220;

  // One YUYV macropixel as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] first_luma;
    logic [7:0] chroma_blue;
    logic [7:0] second_luma;
    logic [7:0] chroma_red;
    logic       frame_end_in;
  } pix_in_t;

  // Two RGB pixels that share the chroma pair, plus the frame flag.
  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_end_out;
  } pix_out_t;

  // One converted pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

/* sv/y2r_if.sv */
// Valid/ready stream interfaces for the converter's input and output words.
// Depends on y2r_pkg for the payload types.
interface y2r_in_if;
  logic             valid;
  logic             ready;
  y2r_pkg::pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface y2r_out_if;
  logic              valid;
  logic              ready;
  y2r_pkg::pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/y2r_pixel.sv */
// Combinational color math for one pixel: fixed-point matrix, clamp, scale.
// Depends on y2r_pkg.
module y2r_pixel #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic [7:0]        luma,
  input  logic signed [8:0] cu,
  input  logic signed [8:0] cv,
  output y2r_pkg::rgb_t     rgb
);
  import y2r_pkg::*;

  // Coefficients fit in one integer bit plus the fraction.
  localparam int CW = COEF_FRAC_BITS + 1;
  // Sums stay below 2^(F+9) in magnitude; one spare bit on top of sign.
  localparam int SW = COEF_FRAC_BITS + 11;

  // Coefficients rounded to nearest from their six-decimal values.
  localparam longint unsigned RV_FULL =
    ((64'd1370705 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned GV_FULL =
    ((64'd698001 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned GU_FULL =
    ((64'd337633 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned BU_FULL =
    ((64'd1732446 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;

  localparam logic [CW-1:0] COEF_RV = CW'(RV_FULL);
  localparam logic [CW-1:0] COEF_GV = CW'(GV_FULL);
  localparam logic [CW-1:0] COEF_GU = CW'(GU_FULL);
  localparam logic [CW-1:0] COEF_BU = CW'(BU_FULL);

  logic signed [SW-1:0] base;
  logic signed [SW-1:0] cu_ext;
  logic signed [SW-1:0] cv_ext;
  logic signed [SW-1:0] rv_prod;
  logic signed [SW-1:0] gv_prod;
  logic signed [SW-1:0] gu_prod;
  logic signed [SW-1:0] bu_prod;
  logic signed [SW-1:0] red_sum;
  logic signed [SW-1:0] green_sum;
  logic signed [SW-1:0] blue_sum;

  // Clamp a fixed-point sum to 0..255 and scale it by 220/256.
  function automatic logic [7:0] clamp_scale(input logic signed [SW-1:0] sum);
    logic [7:0]  clamped;
    logic [15:0] scaled;
    if (sum[SW-1]) begin
      clamped = 8'd0;
    end else if (|sum[SW-2:COEF_FRAC_BITS+8]) begin
      clamped = PIX_MAX;
    end else begin
      clamped = sum[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
    scaled = 16'(clamped) * 16'(SCALE_NUM);
    return scaled[15:8];
  endfunction

  // Luma aligned to the coefficient fraction, chroma sign-extended.
  assign base   = $signed({3'b000, luma, {COEF_FRAC_BITS{1'b0}}});
  assign cu_ext = SW'(cu);
  assign cv_ext = SW'(cv);

  // Constant-coefficient products.
  assign rv_prod = $signed(SW'(COEF_RV)) * cv_ext;
  assign gv_prod = $signed(SW'(COEF_GV)) * cv_ext;
  assign gu_prod = $signed(SW'(COEF_GU)) * cu_ext;
  assign bu_prod = $signed(SW'(COEF_BU)) * cu_ext;

  // Per-channel sums.
  assign red_sum   = base + rv_prod;
  assign green_sum = base - gv_prod - gu_prod;
  assign blue_sum  = base + bu_prod;

  assign rgb.red   = clamp_scale(red_sum);
  assign rgb.green = clamp_scale(green_sum);
  assign rgb.blue  = clamp_scale(blue_sum);

endmodule

/* sv/yuyv422_to_rgb888_convert_core.sv */
// YUYV 4:2:2 to RGB888 converter: input register, color math, result register.
// Depends on y2r_pkg, y2r_if and y2r_pixel.
// An accepted word is held in the input register; its result is offered from the result register.
// Throughput: one word per cycle while pix_out.ready holds; an empty input register refills regardless.
// Reset: synchronous rst empties both stages; no other state is kept.
module yuyv422_to_rgb888_convert_core #(
  parameter int COEF_FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  y2r_in_if.sink     pix_in,
  y2r_out_if.source  pix_out
);
  import y2r_pkg::*;

  logic             in_valid;
  pix_in_t          in_word;
  logic             out_valid;
  pix_out_t         out_word;
  logic             out_advance;
  logic             in_advance;
  logic signed [8:0] cu;
  logic signed [8:0] cv;
  rgb_t             rgb_first;
  rgb_t             rgb_second;
  pix_out_t         result;

  // The result register moves when empty or taken; the input stage follows it.
  assign out_advance  = !out_valid || pix_out.ready;
  assign in_advance   = !in_valid || out_advance;
  assign pix_in.ready = in_advance;

  // Remove the chroma offset.
  assign cu = $signed({1'b0, in_word.chroma_blue}) - 9'(CHROMA_OFFSET);
  assign cv = $signed({1'b0, in_word.chroma_red}) - 9'(CHROMA_OFFSET);

  y2r_pixel #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_pixel_first (
    .luma (in_word.first_luma),
    .cu   (cu),
    .cv   (cv),
    .rgb  (rgb_first)
  );

  y2r_pixel #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_pixel_second (
    .luma (in_word.second_luma),
    .cu   (cu),
    .cv   (cv),
    .rgb  (rgb_second)
  );

  // Pack both pixels and the frame flag into the result word.
  always_comb begin
    result.red_first     = rgb_first.red;
    result.green_first   = rgb_first.green;
    result.blue_first    = rgb_first.blue;
    result.red_second    = rgb_second.red;
    result.green_second  = rgb_second.green;
    result.blue_second   = rgb_second.blue;
    result.frame_end_out = in_word.frame_end_in;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_advance) begin
        in_valid <= pix_in.valid;
      end
      if (out_advance) begin
        out_valid <= in_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (pix_in.valid && in_advance) begin
      in_word <= pix_in.data;
    end
    if (in_valid && out_advance) begin
      out_word <= result;
    end
  end

  assign pix_out.valid = out_valid;
  assign pix_out.data  = out_word;

endmodule

/* tb/yuyv422_to_rgb888_convert_core_tb.sv */
// Self-checking testbench for the YUYV 4:2:2 to RGB888 converter core.
// Depends on y2r_pkg, y2r_if and the core; drives directed and random macropixel words
// under varying back-pressure; checks every result word against a table or color model.
module yuyv422_to_rgb888_convert_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import y2r_pkg::*;

  localparam int FRAC = 16;
  localparam int RANDOM_PER_PHASE = 550;
  localparam int NUM_DIRECTED = 16;

  // Color coefficients, rounded half-up to FRAC fractional bits.
  localparam longint COEF_RV = ((longint'(1370705) << FRAC) + 500000) / 1000000;
  localparam longint COEF_GV = ((longint'(698001) << FRAC) + 500000) / 1000000;
  localparam longint COEF_GU = ((longint'(337633) << FRAC) + 500000) / 1000000;
  localparam longint COEF_BU = ((longint'(1732446) << FRAC) + 500000) / 1000000;

  // One directed word: stimulus, whether the result is typed in, and that result.
  typedef struct packed {
    pix_in_t  stim;
    logic     known;
    pix_out_t want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIRECTED] = '{
    // Black with neutral chroma.
    {8'd0,   8'd128, 8'd0,   8'd128, 1'b0, 1'b1, {6{8'd0}}, 1'b0},
    // Full white with neutral chroma, frame end set.
    {8'd255, 8'd128, 8'd255, 8'd128, 1'b1, 1'b1, {6{8'd219}}, 1'b1},
    // Black then white, and white then black.
    {8'd0,   8'd128, 8'd255, 8'd128, 1'b0, 1'b1, {3{8'd0}}, {3{8'd219}}, 1'b0},
    {8'd255, 8'd128, 8'd0,   8'd128, 1'b1, 1'b1, {3{8'd219}}, {3{8'd0}}, 1'b1},
    // Chroma extremes: negative sums and sums past full scale.
    {8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 49'd0},
    {8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 49'd0},
    {8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 1'b0, 49'd0},
    {8'd255, 8'd0,   8'd0,   8'd255, 1'b1, 1'b0, 49'd0},
    {8'd0,   8'd255, 8'd0,   8'd255, 1'b0, 1'b0, 49'd0},
    {8'd255, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 49'd0},
    // Mid gray and broadcast-range corners.
    {8'd128, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0, 49'd0},
    {8'd16,  8'd240, 8'd235, 8'd16,  1'b0, 1'b0, 49'd0},
    {8'd235, 8'd16,  8'd16,  8'd240, 1'b1, 1'b0, 49'd0},
    // Chroma one step either side of neutral.
    {8'd100, 8'd127, 8'd200, 8'd129, 1'b1, 1'b0, 49'd0},
    {8'd1,   8'd129, 8'd254, 8'd127, 1'b0, 1'b0, 49'd0},
    // Alternating bit patterns.
    {8'd170, 8'd85,  8'd85,  8'd170, 1'b1, 1'b0, 49'd0}
  };

  logic clk;
  logic rst;

  y2r_in_if  pix_in ();
  y2r_out_if pix_out ();

  yuyv422_to_rgb888_convert_core #(
    .COEF_FRAC_BITS(FRAC)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix_in.sink),
    .pix_out(pix_out.source)
  );

  // Results still owed by the core, oldest first.
  pix_out_t rgb_expected[$];

  // Typed-in result that travels with the word being offered.
  logic     offer_known;
  pix_out_t offer_want;

  int src_idle_pct;
  int sink_idle_pct;
  int words_checked;
  int frame_ends_seen;
  int mismatches;
  int random_sent;

  // Fixed-point sum to an 8-bit scaled channel: clamp, then scale by 220/256.
  function automatic logic [7:0] scale_channel(input longint acc);
    longint level;
    if (acc < 0) begin
      return 8'd0;
    end
    level = acc >>> FRAC;
    if (level > longint'(PIX_MAX)) begin
      level = longint'(PIX_MAX);
    end
    return 8'((level * longint'(SCALE_NUM)) >> 8);
  endfunction

  function automatic rgb_t convert_pixel(input logic [7:0] luma, input longint cu,
                                         input longint cv);
    rgb_t   px;
    longint base;
    base = longint'(luma) << FRAC;
    px.red   = scale_channel(base + COEF_RV * cv);
    px.green = scale_channel(base - COEF_GV * cv - COEF_GU * cu);
    px.blue  = scale_channel(base + COEF_BU * cu);
    return px;
  endfunction

  // Both pixels of one macropixel share the chroma pair.
  function automatic pix_out_t convert_macropixel(input pix_in_t w);
    pix_out_t res;
    rgb_t     px0;
    rgb_t     px1;
    longint   cu;
    longint   cv;
    cu  = longint'(w.chroma_blue) - longint'(CHROMA_OFFSET);
    cv  = longint'(w.chroma_red) - longint'(CHROMA_OFFSET);
    px0 = convert_pixel(w.first_luma, cu, cv);
    px1 = convert_pixel(w.second_luma, cu, cv);
    res.red_first     = px0.red;
    res.green_first   = px0.green;
    res.blue_first    = px0.blue;
    res.red_second    = px1.red;
    res.green_second  = px1.green;
    res.blue_second   = px1.blue;
    res.frame_end_out = w.frame_end_in;
    return res;
  endfunction

  // Bytes lean toward the rails and neutral chroma, otherwise uniform.
  function automatic logic [7:0] pick_byte();
    unique case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'(CHROMA_OFFSET);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pix_in_t random_macropixel();
    pix_in_t w;
    w.first_luma   = pick_byte();
    w.chroma_blue  = pick_byte();
    w.second_luma  = pick_byte();
    w.chroma_red   = pick_byte();
    w.frame_end_in = ($urandom_range(7) == 0);
    return w;
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("MISMATCH word %0d %s: expected %0d, got %0d", words_checked, fname,
                 want, got);
      end
      mismatches++;
    end
  endtask

  // Offer one word, with random idle cycles ahead of it; returns at a falling edge.
  task automatic send_word(input pix_in_t w, input logic known, input pix_out_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.data  <= w;
    offer_known  <= known;
    offer_want   <= want;
    do @(posedge clk); while (!pix_in.ready);
    @(negedge clk);
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    @(negedge clk);
    while (rgb_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle.
  initial begin
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      pix_out.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Record accepted words and check result words on the rising edge.
  always @(posedge clk) begin
    pix_out_t want;
    if (!rst && pix_in.valid && pix_in.ready) begin
      if (offer_known) begin
        rgb_expected.push_back(offer_want);
      end else begin
        rgb_expected.push_back(convert_macropixel(pix_in.data));
      end
    end
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (rgb_expected.size() == 0) begin
        if (mismatches < 10) begin
          $display("MISMATCH unexpected result word %0d", words_checked);
        end
        mismatches++;
      end else begin
        want = rgb_expected.pop_front();
        check_field("red_first", want.red_first, pix_out.data.red_first);
        check_field("green_first", want.green_first, pix_out.data.green_first);
        check_field("blue_first", want.blue_first, pix_out.data.blue_first);
        check_field("red_second", want.red_second, pix_out.data.red_second);
        check_field("green_second", want.green_second, pix_out.data.green_second);
        check_field("blue_second", want.blue_second, pix_out.data.blue_second);
        check_field("frame_end_out", 8'(want.frame_end_out), 8'(pix_out.data.frame_end_out));
        if (pix_out.data.frame_end_out === 1'b1) begin
          frame_ends_seen++;
        end
      end
      words_checked++;
    end
  end

  // Stimulus: reset, directed table, then three back-pressure phases of random words.
  initial begin
    int row;
    int ph;
    rst            = 1'b1;
    pix_in.valid   = 1'b0;
    pix_in.data    = '0;
    offer_known    = 1'b0;
    offer_want     = '0;
    src_idle_pct   = 22;
    sink_idle_pct  = 53;
    words_checked  = 0;
    frame_ends_seen = 0;
    mismatches     = 0;
    random_sent    = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (row = 0; row < NUM_DIRECTED; row++) begin
      send_word(DIR_ROWS[row].stim, DIR_ROWS[row].known, DIR_ROWS[row].want);
    end
    wait_drained();

    for (ph = 0; ph < 3; ph++) begin
      unique case (ph)
        0: begin
          src_idle_pct  = 22;
          sink_idle_pct = 53;
        end
        1: begin
          src_idle_pct  = 53;
          sink_idle_pct = 22;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        send_word(random_macropixel(), 1'b0, '0);
        random_sent++;
      end
      wait_drained();
    end

    // Let the two-stage pipe settle so any stray word shows up.
    repeat (8) @(negedge clk);
    $display("Ran %0d directed and %0d random macropixels under three stall patterns.",
             NUM_DIRECTED, random_sent);
    $display("Checked %0d result words, %0d with frame end, %0d mismatches.",
             words_checked, frame_ends_seen, mismatches);
    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("Timed out with %0d result words still owed.", rgb_expected.size());
    $display("status: fail");
    $finish;
  end

endmodule
